[design/rkm_pkg.sv]
// ----------------------------------------------------------------------------
// rkm_pkg
// Shared types and constants for the textbook RSA key and modexp block.
// ----------------------------------------------------------------------------
package rkm_pkg;

    localparam int RKM_MODULUS_BITS = 16;
    localparam int COEF_W           = 18;

    localparam logic [7:0]  PRIME_P_RST = 8'd3;
    localparam logic [7:0]  PRIME_Q_RST = 8'd11;
    localparam logic [15:0] PUB_EXP_RST = 16'd3;

    localparam logic [1:0] REG_PRIME_P = 2'd0;
    localparam logic [1:0] REG_PRIME_Q = 2'd1;
    localparam logic [1:0] REG_PUB_EXP = 2'd2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_INIT,
        ST_E_TEST,
        ST_E_DIV,
        ST_E_UPD,
        ST_X_INIT,
        ST_X_BASE,
        ST_X_TEST,
        ST_X_STA,
        ST_X_DIVA,
        ST_X_MULS,
        ST_X_STS,
        ST_X_DIVS,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_EUCLID,
        DIV_VALUE,
        DIV_PROD
    } div_src_t;

    typedef struct packed {
        logic     load;
        logic     e_init;
        logic     e_mul;
        logic     e_upd;
        logic     e_fin;
        logic     x_init;
        logic     take_base;
        logic     mul_acc;
        logic     take_acc;
        logic     mul_sq;
        logic     take_sq;
        logic     res_zero;
        logic     res_acc;
        logic     div_start;
        div_src_t div_src;
    } cmd_t;

    typedef struct packed {
        logic b2_one;
        logic b2_zero;
        logic div_done;
        logic n_le1;
        logic dec_fail;
        logic exp_zero;
        logic exp_lsb;
    } stat_t;

endpackage

[design/rkm_div.sv]
// ----------------------------------------------------------------------------
// rkm_div
// Restoring divider of 32 by 16 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkm_div
    import rkm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (&cnt_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], ge};
            rem_reg <= ge ? diff[15:0] : trial[15:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[design/rkm_datapath.sv]
// ----------------------------------------------------------------------------
// rkm_datapath
// Euclid coefficient registers, modexp registers, multipliers and divider.
// ----------------------------------------------------------------------------
module rkm_datapath
    import rkm_pkg::*;
#(
    parameter int MODULUS_BITS = RKM_MODULUS_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [7:0]  prime_p,
    input  logic [7:0]  prime_q,
    input  logic [15:0] public_exponent,
    input  logic        opcode,
    input  logic [15:0] value,
    output logic [15:0] result,
    output logic [15:0] private_key,
    output logic        status
);

    localparam int          MB       = (MODULUS_BITS < 16) ? MODULUS_BITS : 16;
    localparam logic [15:0] RES_MASK = 16'((33'd1 << MB) - 33'd1);

    logic                     op_reg;
    logic [15:0]              val_reg;
    logic [15:0]              n_reg;
    logic [15:0]              t_reg;
    logic signed [COEF_W-1:0] a1_reg;
    logic signed [COEF_W-1:0] b1_reg;
    logic [15:0]              a2_reg;
    logic [15:0]              b2_reg;
    logic signed [34:0]       eprod_reg;
    logic [31:0]              prod_reg;
    logic [15:0]              acc_reg;
    logic [15:0]              base_reg;
    logic [15:0]              exp_reg;
    logic [15:0]              d_reg;
    logic                     ok_reg;
    logic [15:0]              res_reg;

    logic [7:0]               pm;
    logic [7:0]               qm;
    logic signed [COEF_W-1:0] n1;
    logic signed [COEF_W-1:0] tb;
    logic [31:0]              div_dividend;
    logic [15:0]              div_divisor;
    logic                     div_done;
    logic [31:0]              div_quo;
    logic [15:0]              div_rem;

    assign pm = (prime_p != 8'd0) ? prime_p - 8'd1 : 8'd0;
    assign qm = (prime_q != 8'd0) ? prime_q - 8'd1 : 8'd0;
    assign n1 = a1_reg - $signed(eprod_reg[COEF_W-1:0]);
    assign tb = $signed({2'b00, t_reg}) + b1_reg;

    always_comb
    begin
        unique case (cmd.div_src)
            DIV_EUCLID:
            begin
                div_dividend = {16'd0, a2_reg};
                div_divisor  = b2_reg;
            end
            DIV_VALUE:
            begin
                div_dividend = {16'd0, val_reg};
                div_divisor  = n_reg;
            end
            default:
            begin
                div_dividend = prod_reg;
                div_divisor  = n_reg;
            end
        endcase
    end

    rkm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            val_reg <= value;
        end
        if (cmd.e_init)
        begin
            n_reg  <= 16'(prime_p) * 16'(prime_q);
            t_reg  <= 16'(pm) * 16'(qm);
            a1_reg <= '0;
            b1_reg <= COEF_W'(1);
            a2_reg <= 16'(pm) * 16'(qm);
            b2_reg <= public_exponent;
        end
        if (cmd.e_mul)
            eprod_reg <= $signed({1'b0, div_quo[15:0]}) * b1_reg;
        if (cmd.e_upd)
        begin
            a1_reg <= b1_reg;
            a2_reg <= b2_reg;
            b1_reg <= n1;
            b2_reg <= div_rem;
        end
        if (cmd.e_fin)
        begin
            ok_reg <= (b2_reg != 16'd0);
            if (b2_reg == 16'd0)
                d_reg <= '0;
            else if (b1_reg > 0)
                d_reg <= b1_reg[15:0];
            else if (b1_reg < 0)
                d_reg <= tb[15:0];
            else
                d_reg <= '0;
        end
        if (cmd.x_init)
        begin
            acc_reg <= 16'd1;
            exp_reg <= (op_reg == OP_DECRYPT) ? d_reg : public_exponent;
        end
        if (cmd.take_base)
            base_reg <= div_rem;
        if (cmd.mul_acc)
            prod_reg <= 32'(acc_reg) * 32'(base_reg);
        if (cmd.mul_sq)
            prod_reg <= 32'(base_reg) * 32'(base_reg);
        if (cmd.take_acc)
            acc_reg <= div_rem;
        if (cmd.take_sq)
        begin
            base_reg <= div_rem;
            exp_reg  <= exp_reg >> 1;
        end
        if (cmd.res_zero)
            res_reg <= '0;
        if (cmd.res_acc)
            res_reg <= acc_reg & RES_MASK;
    end

    assign stat.b2_one   = (b2_reg == 16'd1);
    assign stat.b2_zero  = (b2_reg == 16'd0);
    assign stat.div_done = div_done;
    assign stat.n_le1    = (n_reg <= 16'd1);
    assign stat.dec_fail = (op_reg == OP_DECRYPT) && !ok_reg;
    assign stat.exp_zero = (exp_reg == 16'd0);
    assign stat.exp_lsb  = exp_reg[0];

    assign result      = res_reg;
    assign private_key = d_reg;
    assign status      = !ok_reg;

endmodule

[design/rkm_ctrl.sv]
// ----------------------------------------------------------------------------
// rkm_ctrl
// Sequencer for the inverse search and the square-and-multiply loop.
// ----------------------------------------------------------------------------
module rkm_ctrl
    import rkm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_free,
    output logic  out_load,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_src = DIV_EUCLID;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_E_INIT;
                end
            end
            ST_E_INIT:
            begin
                cmd.e_init = 1'b1;
                state_next = ST_E_TEST;
            end
            ST_E_TEST:
            begin
                if (stat.b2_one || stat.b2_zero)
                begin
                    cmd.e_fin  = 1'b1;
                    state_next = ST_X_INIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_E_DIV;
                end
            end
            ST_E_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.e_mul  = 1'b1;
                    state_next = ST_E_UPD;
                end
            end
            ST_E_UPD:
            begin
                cmd.e_upd  = 1'b1;
                state_next = ST_E_TEST;
            end
            ST_X_INIT:
            begin
                if (stat.n_le1 || stat.dec_fail)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.x_init    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_VALUE;
                    state_next    = ST_X_BASE;
                end
            end
            ST_X_BASE:
            begin
                if (stat.div_done)
                begin
                    cmd.take_base = 1'b1;
                    state_next    = ST_X_TEST;
                end
            end
            ST_X_TEST:
            begin
                if (stat.exp_zero)
                begin
                    cmd.res_acc = 1'b1;
                    state_next  = ST_OUT;
                end
                else if (stat.exp_lsb)
                begin
                    cmd.mul_acc = 1'b1;
                    state_next  = ST_X_STA;
                end
                else
                    state_next = ST_X_MULS;
            end
            ST_X_STA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_PROD;
                state_next    = ST_X_DIVA;
            end
            ST_X_DIVA:
            begin
                if (stat.div_done)
                begin
                    cmd.take_acc = 1'b1;
                    state_next   = ST_X_MULS;
                end
            end
            ST_X_MULS:
            begin
                cmd.mul_sq = 1'b1;
                state_next = ST_X_STS;
            end
            ST_X_STS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_PROD;
                state_next    = ST_X_DIVS;
            end
            ST_X_DIVS:
            begin
                if (stat.div_done)
                begin
                    cmd.take_sq = 1'b1;
                    state_next  = ST_X_TEST;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/rsa_key_and_modexp.sv]
// ----------------------------------------------------------------------------
// rsa_key_and_modexp
// Textbook RSA: private exponent by extended Euclid, then modular power.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                       Word contents
//  s_axis    in         tvalid tready tdata tuser     value; opcode in tuser
//  m_axis    out        tvalid tready tdata tuser     result, private_key; status
//  apb       in         psel penable pwrite paddr ... prime_p, prime_q, public_exponent
//
//  Each word first runs the extended Euclidean search: one pass per quotient,
//  each division going through the shared restoring divider. The power then
//  needs one reduction for the base, one squaring per exponent bit and one
//  multiply per set bit, each reduced through that same divider.
//  Reset clears the sequencer, the divider control and the output valid; the
//  configuration registers return to p = 3, q = 11, e = 3.
//  A finished word waits in the output register while the next word is taken.
//
module rsa_key_and_modexp
    import rkm_pkg::*;
#(
    parameter int MODULUS_BITS = RKM_MODULUS_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] result, [31:16] private_key
    output logic        m_axis_tuser,   // [0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  prime_p_reg;
    logic [7:0]  prime_q_reg;
    logic [15:0] pub_exp_reg;
    logic        cfg_wr;

    logic        out_valid_reg;
    logic [15:0] out_result_reg;
    logic [15:0] out_key_reg;
    logic        out_status_reg;
    logic        out_free;
    logic        out_load;

    cmd_t        cmd;
    stat_t       stat;
    logic [15:0] dp_result;
    logic [15:0] dp_key;
    logic        dp_status;

    // The configuration port never stalls.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg <= PRIME_P_RST;
            prime_q_reg <= PRIME_Q_RST;
            pub_exp_reg <= PUB_EXP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PRIME_P: prime_p_reg <= pwdata[7:0];
                REG_PRIME_Q: prime_q_reg <= pwdata[7:0];
                REG_PUB_EXP: pub_exp_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PRIME_P: prdata = {24'd0, prime_p_reg};
            REG_PRIME_Q: prdata = {24'd0, prime_q_reg};
            REG_PUB_EXP: prdata = {16'd0, pub_exp_reg};
            default:     prdata = '0;
        endcase
    end

    // The sequencer may hand over a new word whenever the output register
    // is empty or is being emptied in the same cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    rkm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    rkm_datapath #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .prime_p         (prime_p_reg),
        .prime_q         (prime_q_reg),
        .public_exponent (pub_exp_reg),
        .opcode          (s_axis_tuser),
        .value           (s_axis_tdata),
        .result          (dp_result),
        .private_key     (dp_key),
        .status          (dp_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_result_reg <= dp_result;
            out_key_reg    <= dp_key;
            out_status_reg <= dp_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_key_reg, out_result_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

[design/rkm_checker.sv]
// ----------------------------------------------------------------------------
// rkm_checker
// Port-level checks on the textbook RSA block, bound to the top level.
// ----------------------------------------------------------------------------
module rkm_checker
    import rkm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A held result word is not withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // One word at a time: the block is busy right after taking a word.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again while a word is in work");

    // A missing inverse always reports a zero private key.
    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:16] == 16'd0))
        else $error("private key not zero with no inverse");

    // No result can appear the cycle after a word is taken.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared too early");

endmodule

bind rsa_key_and_modexp rkm_checker u_rkm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for rsa_key_and_modexp
// Sweeps several prime and exponent settings through the APB port, streams
// encrypt and decrypt words into the block and compares every result word
// with a modexp_tracker that derives the private exponent and the modular
// power on its own, under random idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import rkm_pkg::*;

    // Expected result of one word, field by field.
    typedef struct {
        logic [15:0] result;
        logic [15:0] private_key;
        logic        status;
    } rsa_word_t;

    // Predicts the block and keeps the words still owed by it.
    class modexp_tracker;
        logic [7:0]  p_reg;
        logic [15:0] e_reg;
        logic [7:0]  q_reg;
        rsa_word_t   owed[$];
        int          mismatches;
        int          checked;

        function new();
            p_reg      = PRIME_P_RST;
            q_reg      = PRIME_Q_RST;
            e_reg      = PUB_EXP_RST;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Square-and-multiply; a modulus of 0 or 1 gives 0.
        function longint unsigned power_mod(longint unsigned b, longint unsigned x,
                                            longint unsigned m);
            longint unsigned acc;
            if (m <= 1)
                return 0;
            acc = 1;
            b   = b % m;
            while (x != 0)
            begin
                if (x[0])
                    acc = (acc * b) % m;
                b = (b * b) % m;
                x = x >> 1;
            end
            return acc;
        endfunction

        // Notes an accepted input word and works out its result word.
        function void note_word(logic op, logic [15:0] value);
            longint          a1, a2, b1, b2, qq, n1, n2;
            longint unsigned n, t, pm, qm, d;
            bit              ok;
            rsa_word_t       w;
            n  = longint'(p_reg) * longint'(q_reg);
            pm = (p_reg > 0) ? p_reg - 1 : 0;
            qm = (q_reg > 0) ? q_reg - 1 : 0;
            t  = pm * qm;
            // Extended Euclid on (t, e); only the coefficient of e is kept.
            a1 = 0;
            a2 = t;
            b1 = 1;
            b2 = e_reg;
            while (b2 != 1 && b2 != 0)
            begin
                qq = a2 / b2;
                n1 = a1 - qq * b1;
                n2 = a2 - qq * b2;
                a1 = b1;
                a2 = b2;
                b1 = n1;
                b2 = n2;
            end
            ok = (b2 != 0);
            if (!ok)
                d = 0;
            else if (b1 > 0)
                d = b1;
            else if (b1 < 0)
                d = longint'(t) + b1;
            else
                d = 0;
            if (op == OP_ENCRYPT)
                w.result = 16'(power_mod(value, e_reg, n));
            else
                w.result = ok ? 16'(power_mod(value, d, n)) : 16'd0;
            w.private_key = d[15:0];
            w.status      = !ok;
            owed.push_back(w);
        endfunction

        // Compares one accepted result word with the oldest expectation.
        function void check_word(logic [31:0] data, logic user);
            rsa_word_t w;
            checked++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %h/%b", data, user);
                return;
            end
            w = owed.pop_front();
            if (data[15:0] !== w.result || data[31:16] !== w.private_key
                || user !== w.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: word %0d expected res=%0d key=%0d st=%b, ",
                              "got res=%0d key=%0d st=%b"},
                             checked, w.result, w.private_key, w.status,
                             data[15:0], data[31:16], user);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modexp_tracker tracker;
    int            send_idle_pct;   // chance in a hundred that the sender pauses
    int            recv_idle_pct;   // chance in a hundred that the receiver stalls
    int            words_sent;
    int            words_taken;
    int            hold_left;
    bit            hold_done;
    int            phases_run;

    rsa_key_and_modexp i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] value
        .s_axis_tuser  (s_axis_tuser),   // [0] opcode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] result, [31:16] private_key
        .m_axis_tuser  (m_axis_tuser),   // [0] status
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The whole run is bounded; a hung block ends up here.
    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Writes one register through a setup and an access phase, and keeps the
    // tracker's copy of the configuration in step with it.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRIME_P: tracker.p_reg = val[7:0];
            REG_PRIME_Q: tracker.q_reg = val[7:0];
            REG_PUB_EXP: tracker.e_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] p, input logic [7:0] q,
                              input logic [15:0] e);
        write_reg(REG_PRIME_P, {8'd0, p});
        write_reg(REG_PRIME_Q, {8'd0, q});
        write_reg(REG_PUB_EXP, e);
    endtask

    // Offers one word and waits for the handshake. Valid is only lowered
    // when a pause is taken, so it never toggles twice in one step.
    task automatic send_word(input logic op, input logic [15:0] value);
        // The idling regime follows the progress of the run: the receiver
        // stalls more first, then the sender pauses more, then neither idles.
        if (words_sent < 220)
        begin
            send_idle_pct = 30;
            recv_idle_pct = 53;
        end
        else if (words_sent < 440)
        begin
            send_idle_pct = 53;
            recv_idle_pct = 30;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_word(op, value);
        words_sent++;
    endtask

    // Waits until every owed word has come back, plus some slack, so that
    // the block is idle before the configuration changes.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Random words for one setting: mostly values below the modulus, with a
    // share of full-range values and the extremes mixed in.
    task automatic random_words(input int count);
        int          n;
        int          k;
        logic [15:0] v;
        n = int'(tracker.p_reg) * int'(tracker.q_reg);
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                0:       v = 16'hFFFF;
                1:       v = (n > 0) ? 16'(n - 1) : 16'd0;
                2, 3:    v = 16'($urandom_range(65535));
                default: v = (n > 1) ? 16'($urandom_range(n - 1))
                                     : 16'($urandom_range(65535));
            endcase
            send_word(1'($urandom_range(1)), v);
        end
    endtask

    // Receiver: checks accepted words and decides tready for the next cycle.
    // Once, early in the run, it holds off for a long stretch so that the
    // block fills up and stops taking input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.check_word(m_axis_tdata, m_axis_tuser);
                words_taken++;
            end
            if (!hold_done && words_taken == 60)
            begin
                hold_done = 1'b1;
                hold_left = 6000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        logic [7:0]  pr;
        logic [7:0]  qr;
        logic [15:0] er;
        int          i;
        // Small primes used to build random settings.
        int          primes[16];

        primes        = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 61, 101, 127, 197, 233, 251, 241};
        tracker       = new();
        words_sent    = 0;
        words_taken   = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        phases_run    = 0;
        send_idle_pct = 30;
        recv_idle_pct = 53;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset setting (n = 33, t = 20, d = 7):
        // zero, one, values on and around n, the top of the field and two bit patterns.
        send_word(OP_ENCRYPT, 16'd0);
        send_word(OP_DECRYPT, 16'd0);
        send_word(OP_ENCRYPT, 16'd1);
        send_word(OP_DECRYPT, 16'd1);
        send_word(OP_ENCRYPT, 16'd32);
        send_word(OP_DECRYPT, 16'd32);
        send_word(OP_ENCRYPT, 16'd33);
        send_word(OP_DECRYPT, 16'd34);
        send_word(OP_ENCRYPT, 16'hFFFF);
        send_word(OP_DECRYPT, 16'hFFFF);
        send_word(OP_ENCRYPT, 16'h5555);
        send_word(OP_DECRYPT, 16'hAAAA);
        drain();

        // Totient one: key 0 with status clear, decryption gives 1 mod 4.
        set_config(8'd2, 8'd2, 16'd3);
        send_word(OP_DECRYPT, 16'd3);
        send_word(OP_ENCRYPT, 16'd3);
        drain();
        // Exponent zero: no inverse, encryption gives 1 mod n.
        set_config(8'd5, 8'd7, 16'd0);
        send_word(OP_ENCRYPT, 16'd9);
        send_word(OP_DECRYPT, 16'd9);
        drain();
        // Exponent one and a prime below two, which makes the modulus tiny.
        set_config(8'd1, 8'd1, 16'd1);
        send_word(OP_ENCRYPT, 16'd7);
        send_word(OP_DECRYPT, 16'd7);
        drain();
        set_config(8'd0, 8'd13, 16'd1);
        send_word(OP_ENCRYPT, 16'hFFFF);
        drain();
        // No inverse: e shares a factor with t.
        set_config(8'd11, 8'd13, 16'd6);
        send_word(OP_ENCRYPT, 16'd100);
        send_word(OP_DECRYPT, 16'd100);
        drain();

        // Extremes of every register, then random settings.
        set_config(8'd255, 8'd255, 16'hFFFF);
        random_words(40);
        drain();
        set_config(8'd251, 8'd241, 16'd65535);
        random_words(40);
        drain();
        set_config(8'd3, 8'd11, 16'd7);
        random_words(30);
        drain();
        for (i = 0; i < 11; i++)
        begin
            pr = 8'(primes[$urandom_range(15)]);
            qr = 8'(primes[$urandom_range(15)]);
            case ($urandom_range(3))
                0:       er = 16'($urandom_range(65535));
                1:       er = 16'(32'd65537 - 2 * $urandom_range(1, 100));
                default: er = 16'($urandom_range(2, 200));
            endcase
            set_config(pr, qr, er);
            random_words(45);
            drain();
            phases_run++;
        end

        if (tracker.owed.size() != 0)
        begin
            tracker.mismatches++;
            $display("ERROR: %0d result words never arrived", tracker.owed.size());
        end
        $display("Covered %0d words over %0d random settings plus the directed ones,",
                 words_sent, phases_run);
        $display("with %0d result words checked and %0d mismatches.",
                 words_taken, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[rsa_key_and_modexp.f]
design/rkm_pkg.sv
design/rkm_div.sv
design/rkm_datapath.sv
design/rkm_ctrl.sv
design/rsa_key_and_modexp.sv
design/rkm_checker.sv
tb/tb_top.sv
